[rtl/gsmeg_pkg.sv]
`timescale 1ns / 1ps

package gsmeg_pkg;

    // default limits for the register clamps
    localparam int GRID_MAX_DEF   = 64;
    localparam int FIELDS_MAX_DEF = 4;
    localparam int DIMS_MAX_DEF   = 3;

    // neighbour coordinates can reach grid_size - 2 on a wrap; the width is one bit more than the request
    localparam int CRD_W  = 7;
    localparam int IDX_W  = 22;
    localparam int COEF_W = 4;
    localparam int SLOT_N = 7;
    localparam int SLOT_W = 3;

    localparam logic [1:0] MODE_LAPLACE = 2'd0;
    localparam logic [1:0] MODE_DIV     = 2'd1;
    localparam logic [1:0] MODE_GRAD    = 2'd2;

    localparam logic [1:0] CFG_GRID_SIZE   = 2'd0;
    localparam logic [1:0] CFG_VECTOR_DIMS = 2'd1;
    localparam logic [1:0] CFG_FIELD_COUNT = 2'd2;
    localparam logic [1:0] CFG_PERIODIC    = 2'd3;

    localparam logic [6:0] GRID_SIZE_RST   = 7'd64;
    localparam logic [1:0] VECTOR_DIMS_RST = 2'd3;
    localparam logic [2:0] FIELD_COUNT_RST = 3'd1;

    localparam logic signed [COEF_W-1:0] COEF_DIAG = -4'sd6;
    localparam logic signed [COEF_W-1:0] COEF_NEG  = -4'sd1;
    localparam logic signed [COEF_W-1:0] COEF_POS  = 4'sd1;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] coord_i;
        logic [5:0] coord_j;
        logic [5:0] coord_k;
        logic [1:0] field_sel;
        logic [1:0] component;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [COEF_W-1:0] coeff;
        logic                     last;
    } result_t;

    // one point of the interleaved layout to be flattened
    typedef struct packed {
        logic [CRD_W-1:0] ci;
        logic [CRD_W-1:0] cj;
        logic [CRD_W-1:0] ck;
        logic [1:0]       fsel;
        logic [1:0]       comp;
        logic [1:0]       ncomp;
    } flat_in_t;

endpackage

[rtl/grid_stencil_matrix_entry_generator_top.sv]
// a request is taken into the sequencer registers, and its triplets then pass the slot decode
// registers and the index stages to the one result port. one triplet a cycle while a request
// has triplets left (7 for an interior Laplacian point, 2 for divergence or gradient); busy
// holds off the next request meanwhile. the receiver cannot stall.
// reset clears the registers to their defaults and empties the pipeline.
`timescale 1ns / 1ps

module grid_stencil_matrix_entry_generator_top #(
    parameter int GRID_MAX   = gsmeg_pkg::GRID_MAX_DEF,
    parameter int FIELDS_MAX = gsmeg_pkg::FIELDS_MAX_DEF,
    parameter int DIMS_MAX   = gsmeg_pkg::DIMS_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  gsmeg_pkg::req_t      req,
    output logic                 result_valid,
    output gsmeg_pkg::result_t   result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [6:0]           cfg_data
);

    localparam int CW   = gsmeg_pkg::CRD_W;
    localparam int SN   = gsmeg_pkg::SLOT_N;
    localparam int SW   = gsmeg_pkg::SLOT_W;
    localparam int PIPE = 4;

    // configuration
    logic [6:0] grid_size_reg;
    logic [1:0] vector_dims_reg;
    logic [2:0] field_count_reg;
    logic       periodic_reg;

    logic [6:0] n_eff;
    logic [1:0] nd_eff;
    logic [2:0] nf_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg   <= gsmeg_pkg::GRID_SIZE_RST;
            vector_dims_reg <= gsmeg_pkg::VECTOR_DIMS_RST;
            field_count_reg <= gsmeg_pkg::FIELD_COUNT_RST;
            periodic_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gsmeg_pkg::CFG_GRID_SIZE:   grid_size_reg   <= cfg_data;
                gsmeg_pkg::CFG_VECTOR_DIMS: vector_dims_reg <= cfg_data[1:0];
                gsmeg_pkg::CFG_FIELD_COUNT: field_count_reg <= cfg_data[2:0];
                gsmeg_pkg::CFG_PERIODIC:    periodic_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        n_eff = (grid_size_reg < 7'd3) ? 7'd3 :
                ((int'(grid_size_reg) > GRID_MAX) ? GRID_MAX[6:0] : grid_size_reg);
        nd_eff = (vector_dims_reg < 2'd1) ? 2'd1 :
                 ((int'(vector_dims_reg) > DIMS_MAX) ? DIMS_MAX[1:0] : vector_dims_reg);
        nf_eff = (field_count_reg < 3'd1) ? 3'd1 :
                 ((int'(field_count_reg) > FIELDS_MAX) ? FIELDS_MAX[2:0] : field_count_reg);
    end

    // request decode: which of the up to seven triplets survive the boundary
    logic [CW-1:0] rc [3];
    logic [2:0]    lo_skip, hi_skip;
    logic          req_lap, req_ok;
    logic [SN-1:0] new_mask;
    logic          accept;

    assign accept = start && !busy;

    always_comb
    begin
        rc[0] = CW'(req.coord_i);
        rc[1] = CW'(req.coord_j);
        rc[2] = CW'(req.coord_k);
        for (int a = 0; a < 3; a++)
        begin
            lo_skip[a] = (rc[a] == '0) && !periodic_reg;
            hi_skip[a] = (rc[a] == n_eff - 7'd1) && !periodic_reg;
        end
        req_lap = (req.mode == gsmeg_pkg::MODE_LAPLACE);
        req_ok  = (req.mode inside {gsmeg_pkg::MODE_LAPLACE, gsmeg_pkg::MODE_DIV,
                                    gsmeg_pkg::MODE_GRAD})
                  && (rc[0] < n_eff) && (rc[1] < n_eff) && (rc[2] < n_eff)
                  && ({1'b0, req.field_sel} < nf_eff)
                  && (req_lap ? (req.component < nd_eff) : (req.component != 2'd3));
        if (!req_ok)
            new_mask = '0;
        else if (req_lap)
            new_mask = {!hi_skip[2], !lo_skip[2], !hi_skip[1], !lo_skip[1],
                        !hi_skip[0], !lo_skip[0], 1'b1};
        else
            new_mask = {5'b0, !hi_skip[req.component], !lo_skip[req.component]};
    end

    // sequencer: one surviving triplet per cycle, lowest slot first
    gsmeg_pkg::req_t item_reg;
    logic [SN-1:0]   mask_reg, mask_next;
    logic [SN-1:0]   pick, rest;
    logic [SW-1:0]   slot;

    always_comb
    begin
        pick = mask_reg & (~mask_reg + SN'(1));
        rest = mask_reg & ~pick;
        slot = '0;
        for (int s = 0; s < SN; s++)
        begin
            if (pick[s])
                slot = slot | SW'(s);
        end
        mask_next = accept ? new_mask : rest;
    end

    assign busy = (rest != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= req;
    end

    // slot decode: neighbour coordinate, layouts and coefficient
    gsmeg_pkg::flat_in_t      row_next, col_next, row_reg, col_reg;
    logic signed [gsmeg_pkg::COEF_W-1:0] coeff_next, coeff_reg;
    logic                     p1_valid_reg, last_reg;
    logic [CW-1:0]            ic [3];
    logic [CW-1:0]            pc [3];
    logic [CW-1:0]            cax, nb;
    logic [1:0]               axis;
    logic                     up, diag, lap;

    always_comb
    begin
        ic[0] = CW'(item_reg.coord_i);
        ic[1] = CW'(item_reg.coord_j);
        ic[2] = CW'(item_reg.coord_k);
        lap   = (item_reg.mode == gsmeg_pkg::MODE_LAPLACE);
        diag  = 1'b0;
        up    = 1'b0;
        axis  = item_reg.component;
        if (lap)
        begin
            case (slot)
                3'd0:    diag = 1'b1;
                3'd1:    axis = 2'd0;
                3'd2:    begin axis = 2'd0; up = 1'b1; end
                3'd3:    axis = 2'd1;
                3'd4:    begin axis = 2'd1; up = 1'b1; end
                3'd5:    axis = 2'd2;
                3'd6:    begin axis = 2'd2; up = 1'b1; end
                default: diag = 1'b1;
            endcase
        end
        else
        begin
            up = slot[0];
        end

        case (axis)
            2'd0:    cax = ic[0];
            2'd1:    cax = ic[1];
            default: cax = ic[2];
        endcase

        if (up)
            nb = (cax == n_eff - 7'd1) ? 7'd1 : cax + 7'd1;
        else
            nb = (cax == '0) ? n_eff - 7'd2 : cax - 7'd1;

        for (int a = 0; a < 3; a++)
            pc[a] = (!diag && axis == 2'(a)) ? nb : ic[a];

        row_next.ci   = ic[0];
        row_next.cj   = ic[1];
        row_next.ck   = ic[2];
        row_next.fsel = item_reg.field_sel;
        col_next.ci   = pc[0];
        col_next.cj   = pc[1];
        col_next.ck   = pc[2];
        col_next.fsel = item_reg.field_sel;

        case (item_reg.mode)
            gsmeg_pkg::MODE_DIV:
            begin
                row_next.comp  = 2'd0;
                row_next.ncomp = 2'd1;
                col_next.comp  = item_reg.component;
                col_next.ncomp = 2'd3;
            end
            gsmeg_pkg::MODE_GRAD:
            begin
                row_next.comp  = item_reg.component;
                row_next.ncomp = 2'd3;
                col_next.comp  = 2'd0;
                col_next.ncomp = 2'd1;
            end
            default:
            begin
                row_next.comp  = item_reg.component;
                row_next.ncomp = nd_eff;
                col_next.comp  = item_reg.component;
                col_next.ncomp = nd_eff;
            end
        endcase

        if (diag)
            coeff_next = gsmeg_pkg::COEF_DIAG;
        else if (lap || up)
            coeff_next = gsmeg_pkg::COEF_POS;
        else
            coeff_next = gsmeg_pkg::COEF_NEG;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= (mask_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        coeff_reg <= coeff_next;
        last_reg  <= (rest == '0);
    end

    // index pipelines
    logic [gsmeg_pkg::IDX_W-1:0] row_idx, col_idx;

    gsmeg_flat u_row_flat (
        .clk (clk),
        .n   (n_eff),
        .nf  (nf_eff),
        .pt  (row_reg),
        .idx (row_idx)
    );

    gsmeg_flat u_col_flat (
        .clk (clk),
        .n   (n_eff),
        .nf  (nf_eff),
        .pt  (col_reg),
        .idx (col_idx)
    );

    // side band travelling alongside the index stages
    logic                                vld_pipe_reg [PIPE];
    logic signed [gsmeg_pkg::COEF_W-1:0] coef_pipe_reg [PIPE];
    logic                                last_pipe_reg [PIPE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PIPE; s++)
                vld_pipe_reg[s] <= 1'b0;
        end
        else
        begin
            vld_pipe_reg[0] <= p1_valid_reg;
            for (int s = 1; s < PIPE; s++)
                vld_pipe_reg[s] <= vld_pipe_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        coef_pipe_reg[0] <= coeff_reg;
        last_pipe_reg[0] <= last_reg;
        for (int s = 1; s < PIPE; s++)
        begin
            coef_pipe_reg[s] <= coef_pipe_reg[s-1];
            last_pipe_reg[s] <= last_pipe_reg[s-1];
        end
    end

    assign result_valid     = vld_pipe_reg[PIPE-1];
    assign result.row_index = row_idx;
    assign result.col_index = col_idx;
    assign result.coeff     = coef_pipe_reg[PIPE-1];
    assign result.last      = last_pipe_reg[PIPE-1];

    a_coeff_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.coeff == gsmeg_pkg::COEF_DIAG
                          || result.coeff == gsmeg_pkg::COEF_NEG
                          || result.coeff == gsmeg_pkg::COEF_POS))
        else $error("illegal coefficient on result");

    a_diag_on_diagonal: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.coeff == gsmeg_pkg::COEF_DIAG)
            |-> (result.row_index == result.col_index))
        else $error("diagonal coefficient off the diagonal");

    a_row_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && $past(result_valid) && !$past(result.last))
            |-> (result.row_index == $past(result.row_index)))
        else $error("row changed within one request");

endmodule

[rtl/gsmeg_flat.sv]
`timescale 1ns / 1ps

module gsmeg_flat (
    input  logic                           clk,
    input  logic [6:0]                     n,
    input  logic [2:0]                     nf,
    input  gsmeg_pkg::flat_in_t            pt,
    output logic [gsmeg_pkg::IDX_W-1:0]    idx
);

    localparam int W = gsmeg_pkg::IDX_W;

    logic [W-1:0]                  t1_reg, t1_next;
    logic [W-1:0]                  t2_reg, t2_next;
    logic [W-1:0]                  t3_reg, t3_next;
    logic [W-1:0]                  t4_reg, t4_next;
    logic [gsmeg_pkg::CRD_W-1:0]   i1_reg;
    logic [1:0]                    f1_reg, f2_reg;
    logic [1:0]                    d1_reg, d2_reg, d3_reg;
    logic [1:0]                    c1_reg, c2_reg, c3_reg;

    // (((k*n + j)*n + i)*nf + f)*nc + d, one multiply per stage, kept modulo 2^22
    always_comb
    begin
        t1_next = W'(W'(pt.ck) * W'(n) + W'(pt.cj));
        t2_next = W'(t1_reg * W'(n) + W'(i1_reg));
        t3_next = W'(t2_reg * W'(nf) + W'(f2_reg));
        t4_next = W'(t3_reg * W'(c3_reg) + W'(d3_reg));
    end

    always_ff @(posedge clk)
    begin
        t1_reg <= t1_next;
        i1_reg <= pt.ci;
        f1_reg <= pt.fsel;
        d1_reg <= pt.comp;
        c1_reg <= pt.ncomp;

        t2_reg <= t2_next;
        f2_reg <= f1_reg;
        d2_reg <= d1_reg;
        c2_reg <= c1_reg;

        t3_reg <= t3_next;
        d3_reg <= d2_reg;
        c3_reg <= c2_reg;

        t4_reg <= t4_next;
    end

    assign idx = t4_reg;

endmodule

[dv/tb_grid_stencil_matrix_entry_generator_top.sv]
`timescale 1ns / 1ps

module tb_grid_stencil_matrix_entry_generator_top;

    import gsmeg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 10;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    req_t    req;
    logic    result_valid;
    result_t trip_out;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;

    // register copies as written, clamped only when used
    logic [6:0] cfg_grid;
    logic [1:0] cfg_dims;
    logic [2:0] cfg_fields;
    logic       cfg_periodic;

    result_t pending_triplets[$];
    result_t want;
    int      error_count = 0;
    int      cycle_count = 0;
    bit      idle_en;

    grid_stencil_matrix_entry_generator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (trip_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input longint got, input longint want_v);
        $display("%0t ns mismatch %s: got %0d, want %0d", $time, what, got, want_v);
        error_count++;
    endtask

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint flat_index(input int ci, input int cj, input int ck, input int f,
                                          input int d, input int n, input int nf, input int nc);
        return (((longint'(ck) * n + cj) * n + ci) * nf + f) * nc + d;
    endfunction

    // neighbour one step down or up, wrapped or dropped at the faces
    function automatic bit step_coord(input int c, input bit up, input int n, output int res);
        res = 0;
        if (!up)
        begin
            if (c == 0)
            begin
                if (!cfg_periodic)
                    return 1'b0;
                res = n - 2;
            end
            else
                res = c - 1;
        end
        else
        begin
            if (c == n - 1)
            begin
                if (!cfg_periodic)
                    return 1'b0;
                res = 1;
            end
            else
                res = c + 1;
        end
        return 1'b1;
    endfunction

    function automatic result_t make_trip(input longint row, input longint col,
                                          input logic signed [COEF_W-1:0] coef);
        result_t t;
        t.row_index = row[IDX_W-1:0];
        t.col_index = col[IDX_W-1:0];
        t.coeff     = coef;
        t.last      = 1'b0;
        return t;
    endfunction

    function automatic void expand_stencil(input req_t r);
        int n, nd, nf, f, d, ax, s, v;
        int c[3];
        int p[3];
        longint row, col;
        result_t trip[$];
        n  = clamp_int(int'(cfg_grid), 3, GRID_MAX_DEF);
        nd = clamp_int(int'(cfg_dims), 1, DIMS_MAX_DEF);
        nf = clamp_int(int'(cfg_fields), 1, FIELDS_MAX_DEF);
        c[0] = int'(r.coord_i);
        c[1] = int'(r.coord_j);
        c[2] = int'(r.coord_k);
        f = int'(r.field_sel);
        d = int'(r.component);
        if (r.mode != MODE_LAPLACE && r.mode != MODE_DIV && r.mode != MODE_GRAD)
            return;
        if (c[0] >= n || c[1] >= n || c[2] >= n || f >= nf)
            return;
        if (r.mode == MODE_LAPLACE)
        begin
            if (d >= nd)
                return;
            row = flat_index(c[0], c[1], c[2], f, d, n, nf, nd);
            trip = {trip, make_trip(row, row, COEF_DIAG)};
            for (ax = 0; ax < 3; ax++)
                for (s = 0; s < 2; s++)
                begin
                    p = c;
                    if (step_coord(c[ax], s != 0, n, v))
                    begin
                        p[ax] = v;
                        col = flat_index(p[0], p[1], p[2], f, d, n, nf, nd);
                        trip = {trip, make_trip(row, col, COEF_POS)};
                    end
                end
        end
        else
        begin
            if (d >= 3)
                return;
            // divergence: scalar row, vector column; gradient the other way round
            if (r.mode == MODE_DIV)
                row = flat_index(c[0], c[1], c[2], f, 0, n, nf, 1);
            else
                row = flat_index(c[0], c[1], c[2], f, d, n, nf, 3);
            for (s = 0; s < 2; s++)
            begin
                p = c;
                if (step_coord(c[d], s != 0, n, v))
                begin
                    p[d] = v;
                    if (r.mode == MODE_DIV)
                        col = flat_index(p[0], p[1], p[2], f, d, n, nf, 3);
                    else
                        col = flat_index(p[0], p[1], p[2], f, 0, n, nf, 1);
                    trip = {trip, make_trip(row, col, (s != 0) ? COEF_POS : COEF_NEG)};
                end
            end
        end
        if (trip.size() > 0)
            trip[trip.size() - 1].last = 1'b1;
        pending_triplets = {pending_triplets, trip};
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_triplets.size() == 0)
                flag_mismatch("unexpected triplet, row", longint'(trip_out.row_index), -1);
            else
            begin
                want = pending_triplets.pop_front();
                if (trip_out.row_index !== want.row_index)
                    flag_mismatch("row_index", longint'(trip_out.row_index),
                                  longint'(want.row_index));
                if (trip_out.col_index !== want.col_index)
                    flag_mismatch("col_index", longint'(trip_out.col_index),
                                  longint'(want.col_index));
                if (trip_out.coeff !== want.coeff)
                    flag_mismatch("coeff", longint'(trip_out.coeff), longint'(want.coeff));
                if (trip_out.last !== want.last)
                    flag_mismatch("last", longint'(trip_out.last), longint'(want.last));
            end
        end
    end

    task automatic send_req(input req_t r);
        while (idle_en && $urandom_range(0, 99) < 31)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        // start stays high if the next request follows straight on
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        expand_stencil(r);
    endtask

    // hold off until every triplet is out and the pipeline has emptied
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_triplets.size() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        while (idle_en && $urandom_range(0, 99) < 31)
        begin
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_GRID_SIZE:   cfg_grid = val;
            CFG_VECTOR_DIMS: cfg_dims = val[1:0];
            CFG_FIELD_COUNT: cfg_fields = val[2:0];
            CFG_PERIODIC:    cfg_periodic = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input int grid, input int dims, input int fields, input int per);
        settle();
        write_reg(CFG_GRID_SIZE, 7'(grid));
        write_reg(CFG_VECTOR_DIMS, 7'(dims));
        write_reg(CFG_FIELD_COUNT, 7'(fields));
        write_reg(CFG_PERIODIC, 7'(per));
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t mk_req(input logic [1:0] mode, input int ci, input int cj,
                                    input int ck, input int f, input int d);
        req_t r;
        r.mode      = mode;
        r.coord_i   = 6'(ci);
        r.coord_j   = 6'(cj);
        r.coord_k   = 6'(ck);
        r.field_sel = 2'(f);
        r.component = 2'(d);
        return r;
    endfunction

    // faces are hit often so the boundary handling gets exercised
    function automatic int pick_coord(input int n);
        int sel;
        sel = int'($urandom_range(0, 9));
        if (sel < 2)
            return 0;
        if (sel < 4)
            return n - 1;
        return int'($urandom_range(0, n - 1));
    endfunction

    function automatic req_t rand_req();
        req_t r;
        int n, nd, nf;
        n  = clamp_int(int'(cfg_grid), 3, GRID_MAX_DEF);
        nd = clamp_int(int'(cfg_dims), 1, DIMS_MAX_DEF);
        nf = clamp_int(int'(cfg_fields), 1, FIELDS_MAX_DEF);
        if ($urandom_range(0, 99) < 12)
        begin
            r.mode      = 2'($urandom_range(0, 3));
            r.coord_i   = 6'($urandom_range(0, 63));
            r.coord_j   = 6'($urandom_range(0, 63));
            r.coord_k   = 6'($urandom_range(0, 63));
            r.field_sel = 2'($urandom_range(0, 3));
            r.component = 2'($urandom_range(0, 3));
        end
        else
        begin
            r.mode      = 2'($urandom_range(0, 2));
            r.coord_i   = 6'(pick_coord(n));
            r.coord_j   = 6'(pick_coord(n));
            r.coord_k   = 6'(pick_coord(n));
            r.field_sel = 2'($urandom_range(0, nf - 1));
            r.component = (r.mode == MODE_LAPLACE) ? 2'($urandom_range(0, nd - 1))
                                                   : 2'($urandom_range(0, 2));
        end
        return r;
    endfunction

    // reset values: 64 cells, three components, one field, zero faces
    task automatic test_reset_defaults();
        send_req(mk_req(MODE_LAPLACE, 0, 0, 0, 0, 0));
        send_req(mk_req(MODE_LAPLACE, 63, 63, 63, 0, 2));
        send_req(mk_req(MODE_LAPLACE, 31, 17, 45, 0, 1));
        send_req(mk_req(MODE_DIV, 0, 5, 63, 0, 0));
        send_req(mk_req(MODE_DIV, 0, 5, 63, 0, 2));
        send_req(mk_req(MODE_GRAD, 63, 1, 2, 0, 0));
        send_req(mk_req(MODE_GRAD, 10, 0, 10, 0, 1));
        send_req(mk_req(2'd3, 1, 1, 1, 0, 0));
        send_req(mk_req(MODE_LAPLACE, 4, 4, 4, 1, 0));
        send_req(mk_req(MODE_LAPLACE, 4, 4, 4, 0, 3));
        send_req(mk_req(MODE_DIV, 4, 4, 4, 0, 3));
    endtask

    // smallest grid wrapped: both neighbours can land on the same cell
    task automatic test_periodic_small();
        apply_config(3, 1, 4, 1);
        send_req(mk_req(MODE_LAPLACE, 0, 0, 0, 3, 0));
        send_req(mk_req(MODE_LAPLACE, 2, 1, 2, 0, 0));
        send_req(mk_req(MODE_LAPLACE, 1, 1, 1, 0, 1));
        send_req(mk_req(MODE_DIV, 2, 0, 1, 2, 2));
        send_req(mk_req(MODE_GRAD, 0, 2, 0, 1, 1));
        send_req(mk_req(MODE_GRAD, 1, 1, 1, 3, 0));
        send_req(mk_req(MODE_LAPLACE, 3, 0, 0, 0, 0));
    endtask

    // out-of-range register values are clamped
    task automatic test_clamped_regs();
        apply_config(0, 0, 7, 0);
        send_req(mk_req(MODE_LAPLACE, 2, 2, 2, 3, 0));
        send_req(mk_req(MODE_DIV, 1, 0, 2, 0, 1));
        send_req(mk_req(MODE_GRAD, 2, 1, 0, 3, 2));
        apply_config(127, 3, 0, 1);
        send_req(mk_req(MODE_LAPLACE, 63, 0, 63, 0, 2));
        send_req(mk_req(MODE_DIV, 0, 63, 0, 0, 1));
        send_req(mk_req(MODE_GRAD, 63, 63, 63, 0, 2));
    endtask

    task automatic test_random_phases();
        int ph, q, grid;
        for (ph = 0; ph < 5; ph++)
        begin
            grid = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 127))
                                               : int'($urandom_range(3, 64));
            case (ph)
                0: apply_config(64, 3, 4, 1);
                1: apply_config(3, 1, 1, 0);
                default: apply_config(grid, int'($urandom_range(0, 3)),
                                      int'($urandom_range(0, 7)),
                                      int'($urandom_range(0, 1)));
            endcase
            // one phase runs flat out with no gaps
            idle_en = (ph != 3);
            for (q = 0; q < 40; q++)
                send_req(rand_req());
        end
        idle_en = 1'b1;
    endtask

    initial
    begin
        int waited;
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_GRID_SIZE;
        cfg_data     = '0;
        cfg_grid     = GRID_SIZE_RST;
        cfg_dims     = VECTOR_DIMS_RST;
        cfg_fields   = FIELD_COUNT_RST;
        cfg_periodic = 1'b0;
        idle_en      = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_periodic_small();
        test_clamped_regs();
        test_random_phases();

        start <= 1'b0;
        waited = 0;
        while (pending_triplets.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_triplets.size() != 0)
            flag_mismatch("triplets never emitted", 0, longint'(pending_triplets.size()));

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
